// ----- design/plids_pkg.sv -----
`default_nettype none

package plids_pkg;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_SEARCH = 2'd2;
    localparam logic [1:0] FN_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         position;
        logic signed [31:0] value;
    } req_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [7:0]         found_index;
        logic [7:0]         list_length;
    } rsp_word_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic        we;
        logic        ins;
        logic        find;
        logic [7:0]  pos0;
        logic [31:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/plids_cell.sv -----
`default_nettype none

module plids_cell
    import plids_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 8,
    parameter int KW  = 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cell_ctl_t     ctl,
    input  wire logic [CW-1:0] count,
    input  wire logic [31:0]   left,
    input  wire logic [31:0]   right,
    output logic [31:0]        entry,
    output logic               hit
);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;
    logic        hit_reg;
    logic        hit_next;
    logic [KW-1:0] my_idx;
    logic [KW-1:0] pos_k;

    always_comb
    begin
        my_idx     = KW'(IDX);
        pos_k      = KW'(ctl.pos0);
        entry_next = entry_reg;
        if (ctl.we)
        begin
            if (ctl.ins)
            begin
                if (my_idx == pos_k)
                begin
                    entry_next = ctl.value;
                end
                else if (my_idx > pos_k)
                begin
                    entry_next = left;
                end
            end
            else if (my_idx >= pos_k)
            begin
                entry_next = right;
            end
        end
        // Search flags a live match; every other function flags the selected slot.
        if (ctl.find)
        begin
            hit_next = (my_idx < KW'(count)) && (entry_reg == ctl.value);
        end
        else
        begin
            hit_next = (my_idx == pos_k);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

// ----- design/plids_ptree.sv -----
`default_nettype none

module plids_ptree
    import plids_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int IW    = 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          hit  [DEPTH],
    input  wire logic [31:0]   data [DEPTH],
    output logic [IW-1:0]      root_idx,
    output logic [31:0]        root_data
);

    localparam int LOG = $clog2(DEPTH);
    localparam int P   = 1 << LOG;

    logic          leaf_found [P];
    logic [IW-1:0] leaf_idx   [P];
    logic [31:0]   leaf_data  [P];

    genvar k;
    generate
        for (k = 0; k < P; k++)
        begin : g_leaf
            if (k < DEPTH)
            begin : g_real
                assign leaf_found[k] = hit[k];
                assign leaf_idx[k]   = IW'(k + 1);
                assign leaf_data[k]  = data[k];
            end
            else
            begin : g_pad
                assign leaf_found[k] = 1'b0;
                assign leaf_idx[k]   = '0;
                assign leaf_data[k]  = '0;
            end
        end

        if (P == 1)
        begin : g_single
            assign root_idx  = leaf_found[0] ? leaf_idx[0] : '0;
            assign root_data = leaf_data[0];
        end
        else
        begin : g_tree
            // Heap order: node i has children 2i+1 and 2i+2; leaves follow node P-2.
            logic          node_found_reg [P-1];
            logic [IW-1:0] node_idx_reg   [P-1];
            logic [31:0]   node_data_reg  [P-1];

            genvar i;
            for (i = 0; i < P - 1; i++)
            begin : g_node
                logic          a_found;
                logic          b_found;
                logic [IW-1:0] a_idx;
                logic [IW-1:0] b_idx;
                logic [31:0]   a_data;
                logic [31:0]   b_data;

                if (2 * i + 1 >= P - 1)
                begin : g_from_leaf
                    assign a_found = leaf_found[2 * i + 1 - (P - 1)];
                    assign a_idx   = leaf_idx[2 * i + 1 - (P - 1)];
                    assign a_data  = leaf_data[2 * i + 1 - (P - 1)];
                    assign b_found = leaf_found[2 * i + 2 - (P - 1)];
                    assign b_idx   = leaf_idx[2 * i + 2 - (P - 1)];
                    assign b_data  = leaf_data[2 * i + 2 - (P - 1)];
                end
                else
                begin : g_from_node
                    assign a_found = node_found_reg[2 * i + 1];
                    assign a_idx   = node_idx_reg[2 * i + 1];
                    assign a_data  = node_data_reg[2 * i + 1];
                    assign b_found = node_found_reg[2 * i + 2];
                    assign b_idx   = node_idx_reg[2 * i + 2];
                    assign b_data  = node_data_reg[2 * i + 2];
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        node_found_reg[i] <= 1'b0;
                    end
                    else
                    begin
                        node_found_reg[i] <= a_found | b_found;
                    end
                end

                // Prefer the lower position.
                always_ff @(posedge clk)
                begin
                    node_idx_reg[i]  <= a_found ? a_idx  : b_idx;
                    node_data_reg[i] <= a_found ? a_data : b_data;
                end
            end

            assign root_idx  = node_found_reg[0] ? node_idx_reg[0] : '0;
            assign root_data = node_data_reg[0];
        end
    endgenerate

endmodule

`default_nettype wire

// ----- design/positional_list_insert_delete_search_core.sv -----
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit words held in a row of cells, one
// entry per cell. Every operation (insert, delete, search, clear) passes from
// acceptance to result through the same steps: every cell compares its entry
// into a registered hit flag, then each level of the registered priority tree
// narrows the choice down to the first flagged cell. A successful insert or
// delete shifts all cells in parallel in the final cycle. The block works on
// one request word at a time; a new request is taken as soon as the previous
// result sits in the output register, even while that result is still stalled.
module positional_list_insert_delete_search_core
    import plids_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int KW  = (CW > 8) ? CW : 8;
    localparam int LOG = $clog2(DEPTH);
    localparam int LAT = LOG + 1;
    localparam int WW  = $clog2(LAT + 1);

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t             state_reg;
    logic [WW-1:0]      wait_reg;
    logic [CW-1:0]      count_reg;
    logic               rsp_valid_reg;
    rsp_word_t          rsp_reg;
    logic [1:0]         func_reg;
    logic [7:0]         pos_reg;
    logic [31:0]        value_reg;

    cell_ctl_t          ctl;
    logic [31:0]        entries [DEPTH];
    logic               hits    [DEPTH];
    logic [CW-1:0]      root_idx;
    logic [31:0]        root_data;

    logic               finish;
    logic               write_c;
    logic [1:0]         status_c;
    logic [CW-1:0]      count_c;
    logic [31:0]        removed_c;
    logic [7:0]         found_c;
    logic [KW:0]        pos_w;
    logic [KW:0]        cnt_w;
    rsp_word_t          rsp_c;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic [31:0] left_c;
            logic [31:0] right_c;

            if (k == 0)
            begin : g_first
                assign left_c = '0;
            end
            else
            begin : g_mid_l
                assign left_c = entries[k - 1];
            end

            if (k == DEPTH - 1)
            begin : g_last
                assign right_c = '0;
            end
            else
            begin : g_mid_r
                assign right_c = entries[k + 1];
            end

            plids_cell #(
                .IDX (k),
                .CW  (CW),
                .KW  (KW)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .count (count_reg),
                .left  (left_c),
                .right (right_c),
                .entry (entries[k]),
                .hit   (hits[k])
            );
        end
    endgenerate

    plids_ptree #(
        .DEPTH (DEPTH),
        .IW    (CW)
    ) u_ptree (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit       (hits),
        .data      (entries),
        .root_idx  (root_idx),
        .root_data (root_data)
    );

    always_comb
    begin
        pos_w     = (KW + 1)'(pos_reg);
        cnt_w     = (KW + 1)'(count_reg);
        finish    = (state_reg == S_RUN) && (wait_reg == '0)
                    && (!rsp_valid_reg || !rsp_stall);
        write_c   = 1'b0;
        status_c  = ST_OK;
        count_c   = count_reg;
        removed_c = '0;
        found_c   = '0;

        case (func_reg)
            FN_INSERT:
            begin
                if ((pos_reg == 8'd0) || (pos_w > cnt_w + (KW + 1)'(1)))
                begin
                    status_c = ST_BADPOS;
                end
                else if (cnt_w >= (KW + 1)'(DEPTH))
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    write_c = 1'b1;
                    count_c = count_reg + CW'(1);
                end
            end
            FN_DELETE:
            begin
                if ((pos_reg == 8'd0) || (pos_w > cnt_w))
                begin
                    status_c = ST_BADPOS;
                end
                else
                begin
                    write_c   = 1'b1;
                    removed_c = root_data;
                    count_c   = count_reg - CW'(1);
                end
            end
            FN_SEARCH:
            begin
                found_c = 8'(root_idx);
            end
            FN_CLEAR:
            begin
                count_c = '0;
            end
        endcase

        ctl.we    = finish && write_c;
        ctl.ins   = (func_reg == FN_INSERT);
        ctl.find  = (func_reg == FN_SEARCH);
        ctl.pos0  = pos_reg - 8'd1;
        ctl.value = value_reg;

        rsp_c.status        = status_c;
        rsp_c.removed_value = removed_c;
        rsp_c.found_index   = found_c;
        rsp_c.list_length   = 8'(count_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        wait_reg  <= WW'(LAT);
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_reg <= wait_reg - WW'(1);
                    end
                    else if (finish)
                    begin
                        count_reg     <= count_c;
                        rsp_reg       <= rsp_c;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the request word for the whole operation.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            func_reg  <= req.func;
            pos_reg   <= req.position;
            value_reg <= req.value;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_RUN && wait_reg == WW'(LAT)))
        else $error("accepted word did not start an operation");

    a_write_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.we |-> (state_reg == S_RUN && wait_reg == '0))
        else $error("cell row written before operation end");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == ST_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full status with list not full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> ((KW + 1)'(count_reg) <= (KW + 1)'(DEPTH) && rsp_valid_reg))
        else $error("length exceeds depth or result lost");

endmodule

`default_nettype wire
